FILE: hdl/assert_macros.svh
// assertion helpers, compiled out when SYNTH is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// checked on every rising edge outside reset
`define ERV_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");
// checked on every rising edge, reset included
`define ERV_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ERV_ASSERT(lbl, prop)
`define ERV_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

FILE: hdl/erv_pkg.sv
`default_nettype none

package erv_pkg;

	// fixed field widths
	localparam int ANGLE_BITS = 16;
	localparam int COMP_BITS  = 32;
	// cordic datapath widths
	localparam int XW = 34;
	localparam int ZW = 33;
	// matrix term width, q2.30 with headroom
	localparam int MW = 34;
	// width of an unsaturated rotated component
	localparam int SW = 39;

	localparam logic signed [XW-1:0] CORDIC_GAIN = XW'(652032874);

	// atan(2^-i) in binary angle units, 2^32 per turn
	localparam logic [31:0] ATAN_TBL [0:31] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	typedef struct packed {
		logic signed [ANGLE_BITS-1:0] angle_first;
		logic signed [ANGLE_BITS-1:0] angle_second;
		logic signed [ANGLE_BITS-1:0] angle_third;
		logic signed [COMP_BITS-1:0]  comp_x;
		logic signed [COMP_BITS-1:0]  comp_y;
		logic signed [COMP_BITS-1:0]  comp_z;
	} item_t;

	typedef struct packed {
		logic signed [COMP_BITS-1:0] rot_x;
		logic signed [COMP_BITS-1:0] rot_y;
		logic signed [COMP_BITS-1:0] rot_z;
		logic                        saturated;
	} result_t;

	// state handed from cell to cell: three angles worked side by side
	typedef struct packed {
		logic [2:0][XW-1:0]        x;
		logic [2:0][XW-1:0]        y;
		logic [2:0][ZW-1:0]        z;
		logic [2:0]                flip;
		logic [2:0][COMP_BITS-1:0] v;
	} cord_t;

	typedef struct packed {
		logic [8:0][MW-1:0]        m;
		logic [2:0][COMP_BITS-1:0] v;
	} mat_t;

	typedef struct packed {
		logic [2:0][SW-1:0] r;
	} sum_t;

endpackage

`default_nettype wire

FILE: hdl/euler_angle_vector_rotate.sv
`default_nettype none
`include "assert_macros.svh"

// z-x-z euler rotation of a q16.16 vector. Each transfer brings three 16-bit
// binary angles (full range is minus pi to pi) and a vector; the result is the
// rotated vector, rounded and saturated, with a flag when any component clipped.
// Sines and cosines come from a row of TRIG_STAGES cordic cells, one iteration
// per cell for all three angles; a three-stage matrix unit and a two-stage
// vector multiplier follow, then an output register. Throughput is one item per
// clock unless the output stalls. The whole pipeline stalls only when the
// output register holds a result that is not taken.
module euler_angle_vector_rotate import erv_pkg::*; #(
	parameter int TRIG_STAGES = 16
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    item_valid,
	output logic         item_ready,
	input  wire item_t   item,
	output logic         result_valid,
	input  wire logic    result_ready,
	output result_t      result
);

	logic en;
	cord_t head;
	cord_t chain [0:TRIG_STAGES];
	logic [TRIG_STAGES:0] chain_valid;
	mat_t mat;
	logic mat_valid;
	sum_t sums;
	logic sum_valid;
	result_t result_q;
	result_t res_next;
	logic result_valid_q;
	logic [2:0][ANGLE_BITS-1:0] ang;
	logic [31:0] ph;
	logic fl;
	logic signed [SW-1:0] rv;

	assign en         = !result_valid_q || result_ready;
	assign item_ready = en;

	// fold each phase into the right half plane
	always_comb begin
		ang[0] = item.angle_first;
		ang[1] = item.angle_second;
		ang[2] = item.angle_third;
		head.v[0] = item.comp_x;
		head.v[1] = item.comp_y;
		head.v[2] = item.comp_z;
		ph = '0;
		fl = 1'b0;
		for (int k = 0; k < 3; k++) begin
			ph = {ang[k], (32 - ANGLE_BITS)'(0)};
			fl = ph[31] ^ ph[30];
			head.flip[k] = fl;
			head.x[k] = CORDIC_GAIN;
			head.y[k] = '0;
			head.z[k] = {ph[31] ^ fl, ph[31] ^ fl, ph[30:0]};
		end
	end

	assign chain[0]       = head;
	assign chain_valid[0] = item_valid;

	// cordic cell row
	for (genvar g = 0; g < TRIG_STAGES; g++) begin : g_cell
		erv_cordic_cell #(
			.STAGE(g)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid_in (chain_valid[g]),
			.d_in     (chain[g]),
			.valid_out(chain_valid[g+1]),
			.d_out    (chain[g+1])
		);
	end

	erv_matrix u_matrix (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_in (chain_valid[TRIG_STAGES]),
		.d_in     (chain[TRIG_STAGES]),
		.valid_out(mat_valid),
		.d_out    (mat)
	);

	erv_vec_mul u_vec_mul (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_in (mat_valid),
		.d_in     (mat),
		.valid_out(sum_valid),
		.d_out    (sums)
	);

	// saturate to the component range
	always_comb begin
		res_next = '0;
		rv = '0;
		for (int r = 0; r < 3; r++) begin
			rv = $signed(sums.r[r]);
			if (rv > $signed(SW'({1'b0, {(COMP_BITS-1){1'b1}}}))) begin
				res_next.saturated = 1'b1;
				rv = SW'({1'b0, {(COMP_BITS-1){1'b1}}});
			end else if (rv < -$signed(SW'({1'b1, {(COMP_BITS-1){1'b0}}}))) begin
				res_next.saturated = 1'b1;
				rv = -$signed(SW'({1'b1, {(COMP_BITS-1){1'b0}}}));
			end
			case (r)
				0: res_next.rot_x = rv[COMP_BITS-1:0];
				1: res_next.rot_y = rv[COMP_BITS-1:0];
				default: res_next.rot_z = rv[COMP_BITS-1:0];
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (en) begin
			result_valid_q <= sum_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result_q <= res_next;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// a clipped result has a component at a range end
	`ERV_ASSERT(a_sat_end, result_valid_q && result_q.saturated |-> result_q.rot_x == 32'h7fffffff || result_q.rot_x == 32'h80000000 || result_q.rot_y == 32'h7fffffff || result_q.rot_y == 32'h80000000 || result_q.rot_z == 32'h7fffffff || result_q.rot_z == 32'h80000000)
	// a finished sum reaches the output on the next advance
	`ERV_ASSERT(a_handoff, sum_valid && en |=> result_valid_q)
	// nothing comes out of reset
	`ERV_ASSERT_ALWAYS(a_reset, !arst_n |-> !result_valid_q)

endmodule

`default_nettype wire

FILE: hdl/erv_cordic_cell.sv
`default_nettype none

module erv_cordic_cell import erv_pkg::*; #(
	parameter int STAGE = 0
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  en,
	input  wire logic  valid_in,
	input  wire cord_t d_in,
	output logic       valid_out,
	output cord_t      d_out
);

	cord_t d_next;
	logic signed [XW-1:0] xs, ys, dx, dy;
	logic signed [ZW-1:0] zs, step;

	assign step = $signed({1'b0, ATAN_TBL[STAGE]});

	// one micro-rotation on each of the three angles
	always_comb begin
		d_next = d_in;
		xs = '0;
		ys = '0;
		zs = '0;
		dx = '0;
		dy = '0;
		for (int k = 0; k < 3; k++) begin
			xs = $signed(d_in.x[k]);
			ys = $signed(d_in.y[k]);
			zs = $signed(d_in.z[k]);
			dx = ys >>> STAGE;
			dy = xs >>> STAGE;
			if (!zs[ZW-1]) begin
				d_next.x[k] = xs - dx;
				d_next.y[k] = ys + dy;
				d_next.z[k] = zs - step;
			end else begin
				d_next.x[k] = xs + dx;
				d_next.y[k] = ys - dy;
				d_next.z[k] = zs + step;
			end
		end
	end

	// cell register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (en) begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_out <= d_next;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/erv_matrix.sv
`default_nettype none

module erv_matrix import erv_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  en,
	input  wire logic  valid_in,
	input  wire cord_t d_in,
	output logic       valid_out,
	output mat_t       d_out
);

	localparam logic signed [2*MW-1:0] HALF = (2*MW)'(1) <<< 29;

	function automatic logic signed [MW-1:0] qmul(input logic signed [MW-1:0] a,
			input logic signed [MW-1:0] b);
		logic signed [2*MW-1:0] p;
		p = a * b;
		p = p + HALF;
		return MW'(p >>> 30);
	endfunction

	logic signed [MW-1:0] c1, s1, c2, s2, c3, s3;
	logic valid_s1, valid_s2;

	// first-level products
	logic signed [MW-1:0] c1c3_s1, c2s1_s1, c1s3_s1, c2c3_s1, s1s2_s1, c3s1_s1;
	logic signed [MW-1:0] c1c2_s1, s1s3_s1, c1s2_s1, s2s3_s1, c3s2_s1;
	logic signed [MW-1:0] s1_s1, s3_s1, c2_s1, c3_s1;
	logic [2:0][COMP_BITS-1:0] v_s1;

	// second-level products
	logic signed [MW-1:0] c2s1s3_s2, c2c3s1_s2, c1c2s3_s2, c1c2c3_s2;
	logic signed [MW-1:0] c1c3_s2, c1s3_s2, s1s2_s2, c3s1_s2, s1s3_s2, c1s2_s2;
	logic signed [MW-1:0] s2s3_s2, c3s2_s2, c2_s2;
	logic [2:0][COMP_BITS-1:0] v_s2;

	// undo the half-turn fold on the cordic outputs
	always_comb begin
		c1 = d_in.flip[0] ? -$signed(d_in.x[0]) : $signed(d_in.x[0]);
		s1 = d_in.flip[0] ? -$signed(d_in.y[0]) : $signed(d_in.y[0]);
		c2 = d_in.flip[1] ? -$signed(d_in.x[1]) : $signed(d_in.x[1]);
		s2 = d_in.flip[1] ? -$signed(d_in.y[1]) : $signed(d_in.y[1]);
		c3 = d_in.flip[2] ? -$signed(d_in.x[2]) : $signed(d_in.x[2]);
		s3 = d_in.flip[2] ? -$signed(d_in.y[2]) : $signed(d_in.y[2]);
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			valid_out <= 1'b0;
		end else if (en) begin
			valid_s1  <= valid_in;
			valid_s2  <= valid_s1;
			valid_out <= valid_s2;
		end
	end

	// product stages and term sums
	always_ff @(posedge clk) begin
		if (en) begin
			c1c3_s1 <= qmul(c1, c3);
			c2s1_s1 <= qmul(c2, s1);
			c1s3_s1 <= qmul(c1, s3);
			c2c3_s1 <= qmul(c2, c3);
			s1s2_s1 <= qmul(s1, s2);
			c3s1_s1 <= qmul(c3, s1);
			c1c2_s1 <= qmul(c1, c2);
			s1s3_s1 <= qmul(s1, s3);
			c1s2_s1 <= qmul(c1, s2);
			s2s3_s1 <= qmul(s2, s3);
			c3s2_s1 <= qmul(c3, s2);
			s1_s1   <= s1;
			s3_s1   <= s3;
			c2_s1   <= c2;
			c3_s1   <= c3;
			v_s1    <= d_in.v;

			c2s1s3_s2 <= qmul(c2s1_s1, s3_s1);
			c2c3s1_s2 <= qmul(c2c3_s1, s1_s1);
			c1c2s3_s2 <= qmul(c1c2_s1, s3_s1);
			c1c2c3_s2 <= qmul(c1c2_s1, c3_s1);
			c1c3_s2   <= c1c3_s1;
			c1s3_s2   <= c1s3_s1;
			s1s2_s2   <= s1s2_s1;
			c3s1_s2   <= c3s1_s1;
			s1s3_s2   <= s1s3_s1;
			c1s2_s2   <= c1s2_s1;
			s2s3_s2   <= s2s3_s1;
			c3s2_s2   <= c3s2_s1;
			c2_s2     <= c2_s1;
			v_s2      <= v_s1;

			d_out.m[0] <= c1c3_s2 - c2s1s3_s2;
			d_out.m[1] <= -c1s3_s2 - c2c3s1_s2;
			d_out.m[2] <= s1s2_s2;
			d_out.m[3] <= c3s1_s2 + c1c2s3_s2;
			d_out.m[4] <= c1c2c3_s2 - s1s3_s2;
			d_out.m[5] <= -c1s2_s2;
			d_out.m[6] <= s2s3_s2;
			d_out.m[7] <= c3s2_s2;
			d_out.m[8] <= c2_s2;
			d_out.v    <= v_s2;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/erv_vec_mul.sv
`default_nettype none

module erv_vec_mul import erv_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic en,
	input  wire logic valid_in,
	input  wire mat_t d_in,
	output logic      valid_out,
	output sum_t      d_out
);

	localparam int HW = COMP_BITS - 16 + MW;
	localparam int LW = 17 + MW;
	localparam int PW = LW - 16;
	localparam int TW = LW - 14;
	localparam logic signed [LW-1:0] HALF = LW'(1) <<< 29;

	logic valid_s1;
	logic [2:0][2:0][HW-1:0] ph_s1;
	logic [2:0][2:0][LW-1:0] pl_s1;
	logic [2:0][2:0][HW-1:0] ph_next;
	logic [2:0][2:0][LW-1:0] pl_next;
	sum_t sum_next;

	logic signed [MW-1:0] mv;
	logic signed [HW-1:0] hp;
	logic signed [LW-1:0] lp, acc;
	logic signed [PW-1:0] low_part;
	logic signed [TW-1:0] term;
	logic signed [SW-1:0] tot;

	// split each component into high and low halves and multiply by the terms
	always_comb begin
		mv = '0;
		for (int r = 0; r < 3; r++) begin
			for (int j = 0; j < 3; j++) begin
				mv = $signed(d_in.m[3*r+j]);
				ph_next[r][j] = $signed(d_in.v[j][COMP_BITS-1:16]) * mv;
				pl_next[r][j] = $signed({1'b0, d_in.v[j][15:0]}) * mv;
			end
		end
	end

	// round each term and sum a row
	always_comb begin
		hp = '0;
		lp = '0;
		acc = '0;
		low_part = '0;
		term = '0;
		tot = '0;
		for (int r = 0; r < 3; r++) begin
			tot = '0;
			for (int j = 0; j < 3; j++) begin
				hp = $signed(ph_s1[r][j]);
				lp = $signed(pl_s1[r][j]);
				acc = lp + HALF;
				low_part = PW'(acc >>> 16);
				acc = hp + low_part;
				term = TW'(acc >>> 14);
				tot = tot + term;
			end
			sum_next.r[r] = tot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_out <= 1'b0;
		end else if (en) begin
			valid_s1  <= valid_in;
			valid_out <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ph_s1 <= ph_next;
			pl_s1 <= pl_next;
			d_out <= sum_next;
		end
	end

endmodule

`default_nettype wire
